@@ hdl/jhr_pkg.sv @@
// Shared constants and types of the jaw response curve unit.
`timescale 1ns / 1ps
`default_nettype none
package jhr_pkg;
    localparam int FRAC_BITS = 16;
    localparam int VW = FRAC_BITS + 1;
    localparam int TQ = 20;
    localparam int TDIV_STEPS = 4;
    localparam int PADDR_W = 4;

    localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [VW-1:0] MID = VW'((4 * (1 << FRAC_BITS) + 5) / 10);
    localparam logic [VW-1:0] SPAN_HI = ONE - MID;
    localparam logic [VW-1:0] CAP_START = VW'((12 * (1 << FRAC_BITS) + 5) / 10);
    localparam logic [VW-1:0] CAP_END = VW'((18 * (1 << FRAC_BITS) + 5) / 10);

    localparam logic [13:0] GAIN_K_BASE = 14'd4001;
    localparam logic [13:0] GAIN_K_EXT = 14'd8001;
    localparam logic [31:0] LIMIT_LO = 32'(400) << FRAC_BITS;
    localparam logic [31:0] LIMIT_HI = 32'(600) << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_REST     = 2'd0,
        REG_TYPICAL  = 2'd1,
        REG_MAXIMUM  = 2'd2,
        REG_USE_EXT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [VW-1:0] rest;
        logic [VW-1:0] typical;
        logic [VW-1:0] maximum;
        logic [VW-1:0] h0;
        logic [VW-1:0] h1;
        logic [VW-1:0] ds0;
        logic [VW-1:0] de0;
        logic [VW-1:0] ds1;
        logic [VW-1:0] de1;
        logic          use_ext;
        logic          ok;
    } cfg_t;

    typedef struct packed {
        logic [VW-1:0] raw;
        logic          ok;
        logic          zero;
        logic          full;
        logic          seg;
    } side_t;
endpackage
`default_nettype wire

@@ hdl/jhr_if.sv @@
// Valid/ready channel interfaces for samples and results.
`timescale 1ns / 1ps
`default_nettype none
interface jhr_in_if;
    logic                     valid;
    logic                     ready;
    logic [jhr_pkg::VW-1:0]   jaw_open;
    logic [jhr_pkg::VW-1:0]   jaw_extreme;
    logic                     extreme_present;

    modport source (output valid, jaw_open, jaw_extreme, extreme_present, input ready);
    modport sink (input valid, jaw_open, jaw_extreme, extreme_present, output ready);
endinterface

interface jhr_out_if;
    logic                     valid;
    logic                     ready;
    logic [jhr_pkg::VW-1:0]   response;
    logic                     anchors_valid;

    modport source (output valid, response, anchors_valid, input ready);
    modport sink (input valid, response, anchors_valid, output ready);
endinterface
`default_nettype wire

@@ hdl/jhr_cfg.sv @@
// Register file and tangent precompute sequencer.
`timescale 1ns / 1ps
`default_nettype none
module jhr_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jhr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output jhr_pkg::cfg_t                 cfg,
    output logic                          busy
);
    localparam int VW = jhr_pkg::VW;
    localparam int FB = jhr_pkg::FRAC_BITS;
    localparam int PW = 2 * VW;
    localparam int NUMW = 2 * VW + 7 + FB;
    localparam int DENW = 2 * VW + 8;
    localparam int QW = VW + 2;
    localparam int REMW = NUMW + 1;
    localparam int SHW = DENW + QW;
    localparam int CW = $clog2(QW);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL   = 6'b000010,
        ST_PREP  = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_STORE = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        T_DS0 = 2'd0,
        T_DE0 = 2'd1,
        T_DS1 = 2'd2,
        T_DE1 = 2'd3
    } tan_t;

    logic [VW-1:0]   rest_reg, typ_reg, max_reg;
    logic            ext_reg;
    state_t          state_reg;
    tan_t            idx_reg;
    logic [CW-1:0]   cnt_reg;
    logic [PW-1:0]   pa_reg, pb_reg, pc_reg;
    logic [VW-1:0]   h0_reg, h1_reg;
    logic            ok_reg;
    logic [NUMW-1:0] num_reg;
    logic [DENW-1:0] den_reg;
    logic            zero_reg;
    logic [REMW-1:0] rem_reg;
    logic [SHW-1:0]  dsh_reg;
    logic [QW-1:0]   quo_reg;
    logic [VW-1:0]   ds0_reg, de0_reg, ds1_reg, de1_reg;

    logic            wr;
    logic [VW-1:0]   h0_c, h1_c;
    logic [13:0]     k_c;
    logic [31:0]     ka_c, kb_c;
    logic            ok_c;
    logic [NUMW-1:0] sab_c, sbc_c, ps_c, qs_c, pe_c, qe_c, den1_c, ab18_c, bc18_c;
    logic [NUMW-1:0] num_next;
    logic [DENW-1:0] den_next;
    logic            zero_next;
    logic            ge_c;

    assign wr = psel && penable && pwrite;
    assign busy = (state_reg != ST_IDLE);

    // Anchor spacing check
    assign h0_c = typ_reg - rest_reg;
    assign h1_c = max_reg - typ_reg;
    assign k_c = ext_reg ? jhr_pkg::GAIN_K_EXT : jhr_pkg::GAIN_K_BASE;
    assign ka_c = 32'(k_c) * 32'(h0_c);
    assign kb_c = 32'(k_c) * 32'(h1_c);
    assign ok_c = (typ_reg > rest_reg) && (max_reg > typ_reg)
                  && (jhr_pkg::LIMIT_LO <= ka_c) && (jhr_pkg::LIMIT_HI <= kb_c);

    // Numerators and denominators from the products h0*h0, h0*h1, h1*h1
    always_comb
    begin
        sab_c = NUMW'(pa_reg) + NUMW'(pb_reg);
        sbc_c = NUMW'(pb_reg) + NUMW'(pc_reg);
        ps_c = (NUMW'(pb_reg) << 3) + (NUMW'(pc_reg) << 2);
        qs_c = (NUMW'(pa_reg) << 2) + (NUMW'(pa_reg) << 1);
        pe_c = (NUMW'(pb_reg) << 3) + (NUMW'(pb_reg) << 2)
               + (NUMW'(pa_reg) << 2) + (NUMW'(pa_reg) << 1);
        qe_c = NUMW'(pc_reg) << 2;
        den1_c = (NUMW'(pa_reg) << 4) - NUMW'(pa_reg)
                 + (NUMW'(pb_reg) << 5) + (NUMW'(pb_reg) << 4) + (NUMW'(pb_reg) << 1)
                 + (NUMW'(pc_reg) << 3) + (NUMW'(pc_reg) << 1);
        ab18_c = ((sab_c << 4) + (sab_c << 1)) << FB;
        bc18_c = ((sbc_c << 4) + (sbc_c << 1)) << FB;

        num_next = '0;
        den_next = '0;
        zero_next = 1'b0;
        unique case (idx_reg)
            T_DS0:
            begin
                zero_next = (ps_c <= qs_c);
                num_next = (ps_c - qs_c) << FB;
                den_next = DENW'((sbc_c << 3) + (sbc_c << 1));
            end
            T_DE0:
            begin
                num_next = ab18_c;
                den_next = DENW'(den1_c);
            end
            T_DS1:
            begin
                num_next = bc18_c;
                den_next = DENW'(den1_c);
            end
            T_DE1:
            begin
                zero_next = (pe_c <= qe_c);
                num_next = (pe_c - qe_c) << FB;
                den_next = DENW'((sab_c << 3) + (sab_c << 1));
            end
            default:
            begin
                num_next = '0;
            end
        endcase
    end

    assign ge_c = (SHW'(rem_reg) >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg <= '0;
            typ_reg <= '0;
            max_reg <= '0;
            ext_reg <= 1'b0;
        end
        else if (wr)
        begin
            unique case (jhr_pkg::reg_idx_t'(paddr[jhr_pkg::PADDR_W-1:2]))
                jhr_pkg::REG_REST:    rest_reg <= pwdata[VW-1:0];
                jhr_pkg::REG_TYPICAL: typ_reg <= pwdata[VW-1:0];
                jhr_pkg::REG_MAXIMUM: max_reg <= pwdata[VW-1:0];
                jhr_pkg::REG_USE_EXT: ext_reg <= pwdata[0];
                default:              rest_reg <= rest_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ok_reg <= 1'b0;
        end
        else if (wr)
        begin
            state_reg <= ST_MUL;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:  state_reg <= ST_IDLE;
                ST_MUL:
                begin
                    ok_reg <= ok_c;
                    state_reg <= ST_PREP;
                end
                ST_PREP:  state_reg <= ST_LOAD;
                ST_LOAD:  state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= ST_STORE;
                    end
                end
                ST_STORE:
                begin
                    state_reg <= (idx_reg == T_DE1) ? ST_IDLE : ST_PREP;
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_MUL:
            begin
                pa_reg <= PW'(h0_c) * PW'(h0_c);
                pb_reg <= PW'(h0_c) * PW'(h1_c);
                pc_reg <= PW'(h1_c) * PW'(h1_c);
                h0_reg <= h0_c;
                h1_reg <= h1_c;
                idx_reg <= T_DS0;
            end
            ST_PREP:
            begin
                num_reg <= num_next;
                den_reg <= den_next;
                zero_reg <= zero_next;
            end
            ST_LOAD:
            begin
                // round half up: add half the divisor first
                rem_reg <= REMW'(num_reg) + REMW'(den_reg >> 1);
                dsh_reg <= SHW'(den_reg) << (QW - 1);
                cnt_reg <= CW'(QW - 1);
                quo_reg <= '0;
            end
            ST_DIV:
            begin
                if (ge_c)
                begin
                    rem_reg <= rem_reg - REMW'(dsh_reg);
                end
                quo_reg <= {quo_reg[QW-2:0], ge_c};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            ST_STORE:
            begin
                unique case (idx_reg)
                    T_DS0:
                    begin
                        if (zero_reg)
                            ds0_reg <= '0;
                        else if (quo_reg > QW'(jhr_pkg::CAP_START))
                            ds0_reg <= jhr_pkg::CAP_START;
                        else
                            ds0_reg <= quo_reg[VW-1:0];
                    end
                    T_DE0: de0_reg <= quo_reg[VW-1:0];
                    T_DS1: ds1_reg <= quo_reg[VW-1:0];
                    T_DE1:
                    begin
                        if (zero_reg)
                            de1_reg <= '0;
                        else if (quo_reg > QW'(jhr_pkg::CAP_END))
                            de1_reg <= jhr_pkg::CAP_END;
                        else
                            de1_reg <= quo_reg[VW-1:0];
                    end
                    default: de1_reg <= de1_reg;
                endcase
                idx_reg <= tan_t'(idx_reg + 2'd1);
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    always_comb
    begin
        prdata = '0;
        unique case (jhr_pkg::reg_idx_t'(paddr[jhr_pkg::PADDR_W-1:2]))
            jhr_pkg::REG_REST:    prdata = 32'(rest_reg);
            jhr_pkg::REG_TYPICAL: prdata = 32'(typ_reg);
            jhr_pkg::REG_MAXIMUM: prdata = 32'(max_reg);
            jhr_pkg::REG_USE_EXT: prdata = 32'(ext_reg);
            default:              prdata = '0;
        endcase
    end

    always_comb
    begin
        cfg.rest = rest_reg;
        cfg.typical = typ_reg;
        cfg.maximum = max_reg;
        cfg.use_ext = ext_reg;
        cfg.h0 = h0_reg;
        cfg.h1 = h1_reg;
        cfg.ds0 = ds0_reg;
        cfg.de0 = de0_reg;
        cfg.ds1 = ds1_reg;
        cfg.de1 = de1_reg;
        cfg.ok = ok_reg;
    end

    a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        wr |=> state_reg == ST_MUL)
        else $error("register write did not restart precompute");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0 && !wr) |=> state_reg == ST_STORE)
        else $error("divider did not finish after last quotient bit");

    a_start_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE && idx_reg == T_DS0) |=> ds0_reg <= jhr_pkg::CAP_START)
        else $error("start tangent exceeds cap");
endmodule
`default_nettype wire

@@ hdl/jhr_front.sv @@
// Input conditioning: curve input, segment select and zone flags.
`timescale 1ns / 1ps
`default_nettype none
module jhr_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  jhr_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [jhr_pkg::VW-1:0]    jaw_open,
    input  logic [jhr_pkg::VW-1:0]    jaw_extreme,
    input  logic                      extreme_present,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [jhr_pkg::VW-1:0]    u,
    output logic [jhr_pkg::VW-1:0]    h,
    output jhr_pkg::side_t            side
);
    localparam int VW = jhr_pkg::VW;

    logic          v0_reg, v1_reg;
    logic          en0, en1;
    logic [VW-1:0] x_reg, raw_reg;
    logic [VW-1:0] u_reg, h_reg;
    jhr_pkg::side_t side_reg;

    logic [VW-1:0] base_c, extra_c, x_c;
    logic [VW:0]   sum_c;
    logic          seg_c;

    assign en1 = !v1_reg || out_ready;
    assign en0 = !v0_reg || en1;
    assign in_ready = en0;

    always_comb
    begin
        base_c = (jaw_open > jhr_pkg::ONE) ? jhr_pkg::ONE : jaw_open;
        extra_c = '0;
        if (extreme_present)
        begin
            extra_c = (jaw_extreme > jhr_pkg::ONE) ? jhr_pkg::ONE : jaw_extreme;
        end
        sum_c = {1'b0, base_c} + {1'b0, extra_c};
        x_c = cfg.use_ext ? sum_c[VW:1] : base_c;
    end

    assign seg_c = (x_reg >= cfg.typical);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (en0)
                v0_reg <= in_valid;
            if (en1)
                v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            x_reg <= x_c;
            raw_reg <= jaw_open;
        end
        if (en1)
        begin
            u_reg <= seg_c ? (x_reg - cfg.typical) : (x_reg - cfg.rest);
            h_reg <= seg_c ? cfg.h1 : cfg.h0;
            side_reg.raw <= raw_reg;
            side_reg.ok <= cfg.ok;
            side_reg.zero <= (x_reg <= cfg.rest);
            side_reg.full <= (x_reg >= cfg.maximum);
            side_reg.seg <= seg_c;
        end
    end

    assign out_valid = v1_reg;
    assign u = u_reg;
    assign h = h_reg;
    assign side = side_reg;
endmodule
`default_nettype wire

@@ hdl/jhr_tdiv.sv @@
// Pipelined restoring divider for the segment position t = u * 2^TQ / h.
`timescale 1ns / 1ps
`default_nettype none
module jhr_tdiv #(
    parameter int STEPS = jhr_pkg::TDIV_STEPS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [jhr_pkg::VW-1:0]    u,
    input  logic [jhr_pkg::VW-1:0]    h,
    input  jhr_pkg::side_t            in_side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [jhr_pkg::TQ-1:0]    t,
    output jhr_pkg::side_t            out_side
);
    localparam int VW = jhr_pkg::VW;
    localparam int TQ = jhr_pkg::TQ;
    localparam int NS = (TQ + STEPS - 1) / STEPS;

    logic [NS-1:0]  v_reg;
    logic [NS-1:0]  en;
    logic [VW-1:0]  rem_reg [NS];
    logic [VW-1:0]  h_reg [NS];
    logic [TQ-1:0]  quo_reg [NS];
    jhr_pkg::side_t side_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic           v_in;
        logic [VW-1:0]  rem_in, h_in;
        logic [TQ-1:0]  quo_in;
        jhr_pkg::side_t side_in;
        logic [VW-1:0]  rem_c;
        logic [TQ-1:0]  quo_c;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign rem_in = u;
            assign h_in = h;
            assign quo_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign v_in = v_reg[s-1];
            assign rem_in = rem_reg[s-1];
            assign h_in = h_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        if (s == NS - 1)
        begin : g_last_en
            assign en[s] = !v_reg[s] || out_ready;
        end
        else
        begin : g_mid_en
            assign en[s] = !v_reg[s] || en[s+1];
        end

        // one quotient bit per step; steps past the last bit are skipped
        always_comb
        begin
            logic [VW:0] trial;
            rem_c = rem_in;
            quo_c = quo_in;
            trial = '0;
            for (int j = 0; j < STEPS; j++)
            begin
                if (s * STEPS + j < TQ)
                begin
                    trial = {rem_c, 1'b0};
                    if (trial >= {1'b0, h_in})
                    begin
                        rem_c = VW'(trial - {1'b0, h_in});
                        quo_c = {quo_c[TQ-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_c = trial[VW-1:0];
                        quo_c = {quo_c[TQ-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en[s])
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg[s] <= rem_c;
                h_reg[s] <= h_in;
                quo_reg[s] <= quo_c;
                side_reg[s] <= side_in;
            end
        end
    end

    assign in_ready = en[0];
    assign out_valid = v_reg[NS-1];
    assign t = quo_reg[NS-1];
    assign out_side = side_reg[NS-1];
endmodule
`default_nettype wire

@@ hdl/jhr_basis.sv @@
// Hermite basis evaluation, weighted sum, rounding and output register.
`timescale 1ns / 1ps
`default_nettype none
module jhr_basis (
    input  logic                      clk,
    input  logic                      rst_n,
    input  jhr_pkg::cfg_t             cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [jhr_pkg::TQ-1:0]    t,
    input  jhr_pkg::side_t            in_side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [jhr_pkg::VW-1:0]    response,
    output logic                      anchors_valid
);
    localparam int VW = jhr_pkg::VW;
    localparam int TQ = jhr_pkg::TQ;
    localparam int TW2 = 2 * TQ;
    localparam int BW = TQ + 3;
    localparam int PRW = BW + VW + 1;
    localparam int ACW = PRW + 3;
    localparam int YW = ACW - TQ;
    localparam int NST = 6;
    localparam logic [TW2-1:0] HALF = TW2'(1) << (TQ - 1);
    localparam logic [ACW-1:0] HALF_A = ACW'(1) << (TQ - 1);

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    logic [TQ-1:0]  t1_reg, t2a_reg;
    logic [TQ-1:0]  t2_reg, t2b_reg, t3_reg;
    logic signed [BW-1:0]  b1_reg, b2_reg, b3_reg;
    logic [VW-1:0]  ds_reg, de_reg, sp_reg;
    logic signed [PRW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [ACW-1:0] acc_reg;
    logic [VW-1:0]  resp_reg;
    logic           av_reg;
    jhr_pkg::side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg;

    logic [TW2-1:0] sq_c, cu_c;
    logic [BW-1:0]  b1_c, b2_c, b3_c;
    logic [ACW-1:0] rnd_c;
    logic [YW-1:0]  y_c;
    logic [VW-1:0]  lo_c, hi_c, resp_c;

    for (genvar i = 0; i < NST; i++)
    begin : g_en
        if (i == NST - 1)
        begin : g_last
            assign en[i] = !v_reg[i] || out_ready;
        end
        else
        begin : g_mid
            assign en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign sq_c = (TW2'(t) * TW2'(t) + HALF) >> TQ;
    assign cu_c = (TW2'(t2a_reg) * TW2'(t1_reg) + HALF) >> TQ;

    always_comb
    begin
        b1_c = BW'(t3_reg) - (BW'(t2b_reg) << 1) + BW'(t2_reg);
        b2_c = (BW'(t2b_reg) << 1) + BW'(t2b_reg) - (BW'(t3_reg) << 1);
        b3_c = BW'(t2b_reg) - BW'(t3_reg);
    end

    always_comb
    begin
        lo_c = side5_reg.seg ? jhr_pkg::MID : '0;
        hi_c = side5_reg.seg ? jhr_pkg::ONE : jhr_pkg::MID;
        rnd_c = $unsigned(acc_reg) + HALF_A;
        y_c = acc_reg[ACW-1] ? '0 : rnd_c[ACW-1:TQ];
        if (y_c < YW'(lo_c))
            y_c = YW'(lo_c);
        if (y_c > YW'(hi_c))
            y_c = YW'(hi_c);
        if (!side5_reg.ok)
            resp_c = side5_reg.raw;
        else if (side5_reg.zero)
            resp_c = '0;
        else if (side5_reg.full)
            resp_c = jhr_pkg::ONE;
        else
            resp_c = y_c[VW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            t1_reg <= t;
            t2a_reg <= sq_c[TQ-1:0];
            side1_reg <= in_side;
        end
        if (en[1])
        begin
            t2_reg <= t1_reg;
            t2b_reg <= t2a_reg;
            t3_reg <= cu_c[TQ-1:0];
            side2_reg <= side1_reg;
        end
        if (en[2])
        begin
            b1_reg <= $signed(b1_c);
            b2_reg <= $signed(b2_c);
            b3_reg <= $signed(b3_c);
            ds_reg <= side2_reg.seg ? cfg.ds1 : cfg.ds0;
            de_reg <= side2_reg.seg ? cfg.de1 : cfg.de0;
            sp_reg <= side2_reg.seg ? jhr_pkg::SPAN_HI : jhr_pkg::MID;
            side3_reg <= side2_reg;
        end
        if (en[3])
        begin
            p1_reg <= PRW'(b1_reg) * $signed(PRW'(ds_reg));
            p2_reg <= PRW'(b2_reg) * $signed(PRW'(sp_reg));
            p3_reg <= PRW'(b3_reg) * $signed(PRW'(de_reg));
            side4_reg <= side3_reg;
        end
        if (en[4])
        begin
            acc_reg <= $signed(ACW'(side4_reg.seg ? jhr_pkg::MID : '0) << TQ)
                       + ACW'(p1_reg) + ACW'(p2_reg) - ACW'(p3_reg);
            side5_reg <= side4_reg;
        end
        if (en[5])
        begin
            resp_reg <= resp_c;
            av_reg <= side5_reg.ok;
        end
    end

    assign out_valid = v_reg[NST-1];
    assign response = resp_reg;
    assign anchors_valid = av_reg;
endmodule
`default_nettype wire

@@ hdl/jaw_hermite_response_unit.sv @@
// Top level of the jaw response curve unit.
//
//  channel   direction  handshake       payload
//  sample    in         valid/ready     jaw_open, jaw_extreme, extreme_present
//  result    out        valid/ready     response, anchors_valid
//  apb       in         psel/penable    rest_ceiling, typical_opening,
//                                       maximum_opening, use_extreme
//
// One item per clock sustained while no tangent recompute runs and result is
// ready. After any register write the tangent sequencer runs (one shared
// iterative divider, 19 quotient bits for each of four tangents); sample.ready
// stays low meanwhile. Reset is asynchronous and clears all valid bits, the
// sequencer state and the configuration registers, not the datapath registers.
// A stall on result freezes only the full stages.
`timescale 1ns / 1ps
`default_nettype none
module jaw_hermite_response_unit #(
    parameter int TDIV_STEPS = jhr_pkg::TDIV_STEPS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    jhr_in_if.sink                        sample,
    jhr_out_if.source                     result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jhr_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    localparam int VW = jhr_pkg::VW;
    localparam int TQ = jhr_pkg::TQ;

    jhr_pkg::cfg_t  cfg;
    logic           busy;

    logic           fr_in_valid, fr_in_ready;
    logic           fr_valid, fr_ready;
    logic [VW-1:0]  fr_u, fr_h;
    jhr_pkg::side_t fr_side;

    logic           td_valid, td_ready;
    logic [TQ-1:0]  td_t;
    jhr_pkg::side_t td_side;

    assign pready = 1'b1;

    jhr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg),
        .busy    (busy)
    );

    // hold off samples while tangents are recomputed
    assign fr_in_valid = sample.valid && !busy;
    assign sample.ready = fr_in_ready && !busy;

    jhr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (fr_in_valid),
        .in_ready        (fr_in_ready),
        .jaw_open        (sample.jaw_open),
        .jaw_extreme     (sample.jaw_extreme),
        .extreme_present (sample.extreme_present),
        .out_valid       (fr_valid),
        .out_ready       (fr_ready),
        .u               (fr_u),
        .h               (fr_h),
        .side            (fr_side)
    );

    jhr_tdiv #(
        .STEPS (TDIV_STEPS)
    ) u_tdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .u         (fr_u),
        .h         (fr_h),
        .in_side   (fr_side),
        .out_valid (td_valid),
        .out_ready (td_ready),
        .t         (td_t),
        .out_side  (td_side)
    );

    jhr_basis u_basis (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (td_valid),
        .in_ready      (td_ready),
        .t             (td_t),
        .in_side       (td_side),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .response      (result.response),
        .anchors_valid (result.anchors_valid)
    );

    a_curve_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.anchors_valid) |-> result.response <= jhr_pkg::ONE)
        else $error("curve output above full scale");

    a_write_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite) |=> !sample.ready)
        else $error("sample accepted during tangent precompute");
endmodule
`default_nettype wire

@@ sim/jaw_hermite_response_unit_tb.sv @@
// Self-checking testbench of the jaw response curve unit against a curve predictor.
`timescale 1ns / 1ps
`default_nettype none
module jaw_hermite_response_unit_tb;
    typedef struct packed {
        logic [jhr_pkg::VW-1:0] jaw_open;
        logic [jhr_pkg::VW-1:0] jaw_extreme;
        logic                   extreme_present;
    } sample_t;

    typedef struct packed {
        logic [jhr_pkg::VW-1:0] response;
        logic                   anchors_valid;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [jhr_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    jhr_in_if sample_ch();
    jhr_out_if result_ch();

    jaw_hermite_response_unit dut (
        .clk(clk), .rst_n(rst_n), .sample(sample_ch.sink), .result(result_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    // Curve settings held by the predictor
    longint unsigned c_rest, c_typ, c_max, c_ext;

    sample_t pending_q[$];
    resp_t   curve_q[$];
    int      mismatches = 0;
    bit      calm = 1'b0;
    bit      hold_rx = 1'b0;
    int      src_idle = 0;
    int      snk_idle = 0;

    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
        return (n + d / 2) / d;
    endfunction

    function automatic longint unsigned tangent_end(longint unsigned p, longint unsigned q,
                                                     longint unsigned den,
                                                     longint unsigned cap);
        longint unsigned v;
        if (p <= q)
            return 0;
        v = rdiv((p - q) * 65536, den);
        return v < cap ? v : cap;
    endfunction

    function automatic longint unsigned hermite_level(longint unsigned x);
        longint unsigned h0, h1, s, den1, mid, h, u, lo, hi, ds, de, t, t2, t3, y;
        longint b1, b2, b3, acc;
        if (x <= c_rest)
            return 0;
        if (x >= c_max)
            return 65536;
        h0 = c_typ - c_rest;
        h1 = c_max - c_typ;
        s = h0 + h1;
        den1 = 15 * (2 * h1 + h0) * h0 + 10 * (h1 + 2 * h0) * h1;
        mid = rdiv(4 * 65536, 10);
        if (x < c_typ)
        begin
            h = h0; u = x - c_rest; lo = 0; hi = mid;
            ds = tangent_end(4 * (2 * h0 + h1) * h1, 6 * h0 * h0, 10 * s * h1,
                             rdiv(12 * 65536, 10));
            de = rdiv(18 * h0 * s * 65536, den1);
        end
        else
        begin
            h = h1; u = x - c_typ; lo = mid; hi = 65536;
            ds = rdiv(18 * h1 * s * 65536, den1);
            de = tangent_end(6 * (2 * h1 + h0) * h0, 4 * h1 * h1, 10 * s * h0,
                             rdiv(18 * 65536, 10));
        end
        t = (u << 20) / h;
        if (t > (64'd1 << 20))
            t = 64'd1 << 20;
        t2 = (t * t + (64'd1 << 19)) >> 20;
        t3 = (t2 * t + (64'd1 << 19)) >> 20;
        b1 = longint'(t3) - 2 * longint'(t2) + longint'(t);
        b2 = 3 * longint'(t2) - 2 * longint'(t3);
        b3 = longint'(t2) - longint'(t3);
        acc = longint'(lo << 20) + b1 * longint'(ds) + b2 * longint'(hi - lo)
              - b3 * longint'(de);
        y = acc < 0 ? 0 : (($unsigned(acc) + (64'd1 << 19)) >> 20);
        if (y < lo) y = lo;
        if (y > hi) y = hi;
        return y;
    endfunction

    function automatic resp_t map_sample(sample_t s);
        resp_t r;
        longint unsigned k, base, extra, x;
        bit good;
        k = c_ext ? 8001 : 4001;
        good = c_typ > c_rest && c_max > c_typ
               && 400 * 65536 <= k * (c_typ - c_rest)
               && 600 * 65536 <= k * (c_max - c_typ);
        if (!good)
        begin
            r.response = s.jaw_open;
            r.anchors_valid = 1'b0;
            return r;
        end
        base = s.jaw_open < 65536 ? s.jaw_open : 65536;
        extra = s.extreme_present ? (s.jaw_extreme < 65536 ? s.jaw_extreme : 65536) : 0;
        x = c_ext ? (base + extra) >> 1 : base;
        r.response = jhr_pkg::VW'(hermite_level(x));
        r.anchors_valid = 1'b1;
        return r;
    endfunction

    // Driver: offer the oldest pending item, with random idle bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.jaw_open <= '0;
            sample_ch.jaw_extreme <= '0;
            sample_ch.extreme_present <= 1'b0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                curve_q.push_back(map_sample(pending_q.pop_front()));
                if (!calm && $urandom_range(0, 15) == 0)
                    src_idle = $urandom_range(1, 18);
            end
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (src_idle > 0)
                begin
                    src_idle--;
                    sample_ch.valid <= 1'b0;
                end
                else if (pending_q.size() > 0)
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.jaw_open <= pending_q[0].jaw_open;
                    sample_ch.jaw_extreme <= pending_q[0].jaw_extreme;
                    sample_ch.extreme_present <= pending_q[0].extreme_present;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every accepted result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (curve_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d/%0d", result_ch.response,
                                 result_ch.anchors_valid);
                end
                else
                begin
                    resp_t e;
                    e = curve_q.pop_front();
                    if (e.response !== result_ch.response
                        || e.anchors_valid !== result_ch.anchors_valid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d/%0d got %0d/%0d",
                                     e.response, e.anchors_valid,
                                     result_ch.response, result_ch.anchors_valid);
                    end
                end
            end
            if (hold_rx)
                result_ch.ready <= 1'b0;
            else if (snk_idle > 0)
            begin
                snk_idle--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (!calm && $urandom_range(0, 15) == 0)
                    snk_idle = $urandom_range(1, 18);
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(jhr_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= jhr_pkg::PADDR_W'(4 * int'(idx)); pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            jhr_pkg::REG_REST:    c_rest = 64'(val[jhr_pkg::VW-1:0]);
            jhr_pkg::REG_TYPICAL: c_typ = 64'(val[jhr_pkg::VW-1:0]);
            jhr_pkg::REG_MAXIMUM: c_max = 64'(val[jhr_pkg::VW-1:0]);
            jhr_pkg::REG_USE_EXT: c_ext = 64'(val[0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && curve_q.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic set_curve(int r, int t, int m, int e);
        reg_write(jhr_pkg::REG_REST, r);
        reg_write(jhr_pkg::REG_TYPICAL, t);
        reg_write(jhr_pkg::REG_MAXIMUM, m);
        reg_write(jhr_pkg::REG_USE_EXT, e);
    endtask

    function automatic sample_t rand_sample();
        sample_t s;
        int sel;
        sel = $urandom_range(0, 9);
        s.jaw_open = sel == 0 ? jhr_pkg::VW'($urandom)
                              : jhr_pkg::VW'($urandom_range(0, 65536));
        s.jaw_extreme = sel == 1 ? jhr_pkg::VW'($urandom)
                                 : jhr_pkg::VW'($urandom_range(0, 65536));
        s.extreme_present = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic push(int jo, int je, int ep);
        sample_t s;
        s.jaw_open = jhr_pkg::VW'(jo);
        s.jaw_extreme = jhr_pkg::VW'(je);
        s.extreme_present = 1'(ep);
        pending_q.push_back(s);
    endtask

    initial
    begin
        int r, t, m;
        c_rest = 0; c_typ = 0; c_max = 0; c_ext = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Reset anchors fail the spacing check: raw passthrough
        push(0, 0, 0); push(65536, 0, 1); push(131071, 131071, 1);
        drain();
        set_curve(6554, 26214, 58982, 0);
        push(0, 0, 0); push(6554, 0, 0); push(6555, 0, 0); push(26213, 0, 0);
        push(26214, 0, 0); push(26215, 0, 0); push(58981, 0, 0); push(58982, 0, 0);
        push(65536, 0, 0); push(131071, 0, 0); push(40000, 65536, 1);
        drain();
        set_curve(6554, 26214, 58982, 1);
        push(40000, 65536, 1); push(40000, 65536, 0); push(131071, 131071, 1);
        push(0, 131071, 1); push(65536, 65536, 1);
        drain();
        // h0 at the gain limit, then just under it; h1 the reverse
        set_curve(0, 6552, 16379, 0);
        push(3000, 0, 0); push(10000, 0, 0);
        drain();
        set_curve(0, 6551, 16379, 0);
        push(3000, 0, 0);
        drain();
        set_curve(0, 3277, 8193, 1);
        push(3000, 3000, 1); push(7000, 9000, 1);
        drain();
        // Long receiver stall while items keep coming
        for (int i = 0; i < 60; i++)
            pending_q.push_back(rand_sample());
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
        drain();
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: begin r = $urandom_range(0, 20000); t = r + $urandom_range(7000, 25000);
                       m = t + $urandom_range(10000, 131071 - t > 10000 ? 131071 - t : 10000);
                   end
                1: begin r = $urandom_range(0, 131071); t = $urandom_range(0, 131071);
                       m = $urandom_range(0, 131071); end
                2: begin r = 0; t = 26214; m = 65536; end
                default: begin r = $urandom_range(0, 2000); t = r + $urandom_range(3200, 7000);
                       m = t + $urandom_range(5000, 20000); end
            endcase
            if (m > 131071) m = 131071;
            set_curve(r, t, m, $urandom_range(0, 1));
            if (ph == 11)
                calm = 1'b1;
            for (int i = 0; i < 150; i++)
                pending_q.push_back(rand_sample());
            drain();
        end
        if (mismatches == 0)
            $display("jaw_hermite_response_unit_tb: done, clean");
        else
            $display("jaw_hermite_response_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("jaw_hermite_response_unit_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
hdl/jhr_pkg.sv
hdl/jhr_if.sv
hdl/jhr_cfg.sv
hdl/jhr_front.sv
hdl/jhr_tdiv.sv
hdl/jhr_basis.sv
hdl/jaw_hermite_response_unit.sv
sim/jaw_hermite_response_unit_tb.sv
